FILE: sv/cba_pkg.sv
`default_nettype none
package cba_pkg;

    localparam int KIND_W  = 2;
    localparam int BYTES_W = 16;
    localparam int FOWN_W  = 8;
    localparam int STAT_W  = 2;
    localparam int OID_W   = 8;
    localparam int START_W = 7;
    localparam int CNT_W   = 8;
    localparam int NEED_W  = 16;

    localparam logic [KIND_W-1:0] KIND_FIRST = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NEXT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BEST  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOFIT = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ZERO  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_IDS   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHECK,
        ST_SCAN,
        ST_PICK,
        ST_WRITE,
        ST_FINISH
    } cba_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic div_start;
        logic check;
        logic scan_start;
        logic pick;
        logic write;
        logic emit;
    } cba_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_free;
        logic div_done;
        logic check_fail;
        logic scan_done;
        logic pick_fail;
        logic wr_done;
        logic out_free;
    } cba_stat_t;

endpackage
`default_nettype wire

FILE: sv/cba_if.sv
`default_nettype none
interface cba_req_if;
    import cba_pkg::*;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [BYTES_W-1:0]  request_bytes;
    logic [FOWN_W-1:0]   free_owner;
    modport source (output valid, kind, request_bytes, free_owner, input ready);
    modport sink   (input valid, kind, request_bytes, free_owner, output ready);
endinterface

interface cba_rsp_if;
    import cba_pkg::*;
    logic                valid;
    logic                ready;
    logic [STAT_W-1:0]   status;
    logic [OID_W-1:0]    owner_id;
    logic [START_W-1:0]  start_block;
    logic [CNT_W-1:0]    block_count;
    modport source (output valid, status, owner_id, start_block, block_count, input ready);
    modport sink   (input valid, status, owner_id, start_block, block_count, output ready);
endinterface

interface cba_cfg_if;
    import cba_pkg::*;
    logic                valid;
    logic                ready;
    logic [BYTES_W-1:0]  data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: sv/contiguous_block_allocator_unit.sv
// Contiguous block allocator: a map of NUM_BLOCKS blocks, each tagged with
// its owner id (0 = free).
// req beat: kind (first/next/best fit allocate, or free owner), request_bytes,
//   free_owner. rsp beat: status, owner_id, start_block, block_count, one per
//   req beat. cfg beat: block_size; cfg.ready is always high.
// One item at a time. An allocate runs a 16-bit bit-serial divide for the
// block count, a check step, one pass over the map (one block per cycle
// through the registered map read), a pick step and one write per allocated
// block before rsp.valid. A rejected allocate (zero size, ids used up, too
// big) answers after the divide and check. A free is one map pass.
// A finished result sits in the rsp register; the next req is taken while it
// waits. If rsp is still stalled when the following result is ready, the
// block holds in its finish state until rsp.ready.
// Reset clears the valid bit of every block at once (all free), owner ids
// restart at 1, next fit restarts at block 0, block_size is 1.
`default_nettype none
module contiguous_block_allocator_unit #(
    parameter int NUM_BLOCKS = 128,
    parameter int OWNER_BITS = 8
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    cba_req_if.sink     req,
    cba_rsp_if.source   rsp,
    cba_cfg_if.sink     cfg
);
    import cba_pkg::*;

    cba_cmd_t  cmd;
    cba_stat_t stat;

    // config writes land straight in the block_size register
    assign cfg.ready = 1'b1;

    cba_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .in_is_free (req.kind == KIND_FREE),
        .in_ready   (req.ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    cba_datapath #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .OWNER_BITS (OWNER_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .in_kind         (req.kind),
        .in_bytes        (req.request_bytes),
        .in_fown         (req.free_owner),
        .cfg_we          (cfg.valid),
        .cfg_data        (cfg.data),
        .out_ready       (rsp.ready),
        .out_valid       (rsp.valid),
        .out_status      (rsp.status),
        .out_owner_id    (rsp.owner_id),
        .out_start_block (rsp.start_block),
        .out_block_count (rsp.block_count)
    );

endmodule
`default_nettype wire

FILE: sv/cba_div.sv
`default_nettype none
module cba_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [cba_pkg::NEED_W-1:0]   dividend,
    input  logic [cba_pkg::NEED_W-1:0]   divisor,
    output logic                         done,
    output logic [cba_pkg::NEED_W-1:0]   quotient,
    output logic [cba_pkg::NEED_W-1:0]   remainder
);
    import cba_pkg::*;

    localparam int SW = $clog2(NEED_W);

    logic [NEED_W-1:0] rem_reg, rem_next;
    logic [NEED_W-1:0] quo_reg, quo_next;
    logic [NEED_W-1:0] dvsr_reg;
    logic [SW-1:0]     cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [NEED_W:0]   shifted;
    logic [NEED_W:0]   diff;
    logic              ge;

    // restoring, one quotient bit per cycle
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[NEED_W-1]};
        ge       = shifted >= {1'b0, dvsr_reg};
        diff     = shifted - {1'b0, dvsr_reg};
        rem_next = ge ? diff[NEED_W-1:0] : shifted[NEED_W-1:0];
        quo_next = {quo_reg[NEED_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == SW'(NEED_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            quo_reg  <= dividend;
            dvsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

FILE: sv/cba_datapath.sv
`default_nettype none
module cba_datapath #(
    parameter int NUM_BLOCKS = 128,
    parameter int OWNER_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cba_pkg::cba_cmd_t             cmd,
    output cba_pkg::cba_stat_t            stat,
    input  logic [cba_pkg::KIND_W-1:0]    in_kind,
    input  logic [cba_pkg::BYTES_W-1:0]   in_bytes,
    input  logic [cba_pkg::FOWN_W-1:0]    in_fown,
    input  logic                          cfg_we,
    input  logic [cba_pkg::BYTES_W-1:0]   cfg_data,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [cba_pkg::STAT_W-1:0]    out_status,
    output logic [cba_pkg::OID_W-1:0]     out_owner_id,
    output logic [cba_pkg::START_W-1:0]   out_start_block,
    output logic [cba_pkg::CNT_W-1:0]     out_block_count
);
    import cba_pkg::*;

    localparam int AW = $clog2(NUM_BLOCKS);
    localparam int LW = $clog2(NUM_BLOCKS + 1);
    localparam int CW = NEED_W + 2;
    localparam int XW = (OWNER_BITS > FOWN_W) ? OWNER_BITS : FOWN_W;

    // owner map, valid bit per block (invalid reads as free)
    logic [OWNER_BITS-1:0] map_mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] valid_reg;

    logic [BYTES_W-1:0]    block_size_reg;
    logic [OWNER_BITS-1:0] next_owner_reg;
    logic [AW-1:0]         rover_reg;

    logic [KIND_W-1:0]     kind_reg;
    logic [FOWN_W-1:0]     fown_reg;
    logic [NEED_W-1:0]     need_reg;

    logic [NEED_W-1:0]     bs_eff;
    logic                  div_done;
    logic [NEED_W-1:0]     div_quo;
    logic [NEED_W-1:0]     div_rem;

    // scan pipeline
    logic [AW-1:0]         scan_addr_reg;
    logic                  issuing_reg;
    logic                  proc_vld_reg;
    logic [AW-1:0]         proc_addr_reg;
    logic                  proc_last_reg;
    logic [OWNER_BITS-1:0] rd_data_reg;
    logic                  rd_vld_reg;

    // run trackers
    logic [LW-1:0]         run_len_reg;
    logic [AW-1:0]         run_start_reg;
    logic                  ff_found_reg, nf_found_reg, bf_found_reg;
    logic [AW-1:0]         ff_pos_reg, nf_pos_reg, bf_pos_reg;
    logic [LW-1:0]         bf_len_reg;

    // free accumulators
    logic [LW-1:0]         free_cnt_reg;
    logic [AW-1:0]         free_start_reg;

    // write sweep
    logic [AW-1:0]         where_reg;
    logic [AW-1:0]         wr_ptr_reg;
    logic [LW-1:0]         wr_left_reg;

    logic [STAT_W-1:0]     res_status_reg;
    logic [OID_W-1:0]      res_id_reg;
    logic [START_W-1:0]    res_start_reg;
    logic [CNT_W-1:0]      res_count_reg;

    logic                  out_valid_reg;
    logic [STAT_W-1:0]     out_status_reg;
    logic [OID_W-1:0]      out_id_reg;
    logic [START_W-1:0]    out_start_reg;
    logic [CNT_W-1:0]      out_count_reg;

    logic                  blk_free;
    logic [LW-1:0]         cur_len;
    logic [AW-1:0]         cur_start;
    logic                  run_close;
    logic                  fits;
    logic [CW-1:0]         last_cand;
    logic                  own_match;
    logic                  is_free;
    logic [STAT_W-1:0]     chk_status;
    logic                  chk_fail;
    logic                  pick_ok;
    logic [AW-1:0]         pick_where;
    logic [CW-1:0]         rover_sum;
    logic                  wr_last;

    assign bs_eff  = (block_size_reg == '0) ? NEED_W'(1) : block_size_reg;
    assign is_free = (kind_reg == KIND_FREE);

    // divide starts on the accept edge, so it takes the size straight off the beat
    cba_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (in_bytes),
        .divisor   (bs_eff),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // run tracking on the block being processed
    always_comb
    begin
        blk_free  = !rd_vld_reg;
        cur_len   = blk_free ? run_len_reg + 1'b1 : run_len_reg;
        cur_start = (blk_free && run_len_reg == '0) ? proc_addr_reg : run_start_reg;
        run_close = proc_vld_reg && (!blk_free || proc_last_reg);
        fits      = CW'(cur_len) >= CW'(need_reg);
        last_cand = CW'(cur_start) + CW'(cur_len) - CW'(need_reg);
        own_match = rd_vld_reg && (XW'(rd_data_reg) == XW'(fown_reg));
    end

    always_comb
    begin
        chk_status = STAT_OK;
        if (need_reg == '0)
            chk_status = STAT_ZERO;
        else if (next_owner_reg == '0)
            chk_status = STAT_IDS;
        else if (CW'(need_reg) > CW'(NUM_BLOCKS))
            chk_status = STAT_NOFIT;
        chk_fail = (chk_status != STAT_OK);
    end

    always_comb
    begin
        pick_ok    = 1'b0;
        pick_where = ff_pos_reg;
        case (kind_reg)
            KIND_FIRST:
            begin
                pick_ok    = ff_found_reg;
                pick_where = ff_pos_reg;
            end
            KIND_NEXT:
            begin
                pick_ok    = nf_found_reg || ff_found_reg;
                pick_where = nf_found_reg ? nf_pos_reg : ff_pos_reg;
            end
            KIND_BEST:
            begin
                pick_ok    = bf_found_reg;
                pick_where = bf_pos_reg;
            end
            default:
            begin
                pick_ok    = 1'b0;
                pick_where = ff_pos_reg;
            end
        endcase
    end

    assign rover_sum = CW'(where_reg) + CW'(need_reg);
    assign wr_last   = (wr_left_reg == LW'(1));

    always_ff @(posedge clk)
    begin
        if (cmd.write)
            map_mem[wr_ptr_reg] <= next_owner_reg;
        rd_data_reg <= map_mem[scan_addr_reg];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            block_size_reg <= BYTES_W'(1);
            next_owner_reg <= OWNER_BITS'(1);
            rover_reg      <= '0;
            issuing_reg    <= 1'b0;
            proc_vld_reg   <= 1'b0;
            rd_vld_reg     <= 1'b0;
            ff_found_reg   <= 1'b0;
            nf_found_reg   <= 1'b0;
            bf_found_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                block_size_reg <= cfg_data;

            rd_vld_reg   <= valid_reg[scan_addr_reg];
            proc_vld_reg <= issuing_reg;
            if (cmd.scan_start)
            begin
                issuing_reg  <= 1'b1;
                ff_found_reg <= 1'b0;
                nf_found_reg <= 1'b0;
                bf_found_reg <= 1'b0;
            end
            else if (issuing_reg && scan_addr_reg == AW'(NUM_BLOCKS - 1))
                issuing_reg <= 1'b0;

            if (run_close && fits && !is_free)
            begin
                ff_found_reg <= 1'b1;
                if (!nf_found_reg &&
                    (cur_start >= rover_reg || last_cand >= CW'(rover_reg)))
                    nf_found_reg <= 1'b1;
                bf_found_reg <= 1'b1;
            end

            if (proc_vld_reg && is_free && own_match)
                valid_reg[proc_addr_reg] <= 1'b0;

            if (cmd.write)
            begin
                valid_reg[wr_ptr_reg] <= 1'b1;
                if (wr_last)
                begin
                    rover_reg <= (rover_sum >= CW'(NUM_BLOCKS))
                               ? AW'(rover_sum - CW'(NUM_BLOCKS)) : AW'(rover_sum);
                    next_owner_reg <= (next_owner_reg == {OWNER_BITS{1'b1}})
                                    ? '0 : next_owner_reg + 1'b1;
                end
            end

            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload and trackers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg       <= in_kind;
            fown_reg       <= in_fown;
            res_status_reg <= STAT_OK;
            res_id_reg     <= (in_kind == KIND_FREE) ? in_fown : '0;
            res_start_reg  <= '0;
            res_count_reg  <= '0;
            free_cnt_reg   <= '0;
            free_start_reg <= '0;
        end

        if (div_done)
            need_reg <= div_quo + NEED_W'(div_rem != '0);

        if (cmd.check)
            res_status_reg <= chk_status;

        if (cmd.scan_start)
        begin
            scan_addr_reg <= '0;
            run_len_reg   <= '0;
            run_start_reg <= '0;
        end
        else if (issuing_reg)
            scan_addr_reg <= scan_addr_reg + 1'b1;
        proc_addr_reg <= scan_addr_reg;
        proc_last_reg <= (scan_addr_reg == AW'(NUM_BLOCKS - 1));

        if (proc_vld_reg)
        begin
            if (blk_free)
            begin
                run_len_reg   <= cur_len;
                run_start_reg <= cur_start;
            end
            else
                run_len_reg <= '0;
            if (is_free && own_match)
            begin
                free_cnt_reg <= free_cnt_reg + 1'b1;
                if (free_cnt_reg == '0)
                    free_start_reg <= proc_addr_reg;
            end
        end

        if (run_close && fits && !is_free)
        begin
            if (!ff_found_reg)
                ff_pos_reg <= cur_start;
            if (!nf_found_reg)
            begin
                if (cur_start >= rover_reg)
                    nf_pos_reg <= cur_start;
                else if (last_cand >= CW'(rover_reg))
                    nf_pos_reg <= rover_reg;
            end
            if (!bf_found_reg || cur_len < bf_len_reg)
            begin
                bf_pos_reg <= cur_start;
                bf_len_reg <= cur_len;
            end
        end

        if (cmd.pick)
        begin
            where_reg   <= pick_where;
            wr_ptr_reg  <= pick_where;
            wr_left_reg <= LW'(need_reg);
            if (!pick_ok)
                res_status_reg <= STAT_NOFIT;
        end

        if (cmd.write)
        begin
            wr_ptr_reg  <= wr_ptr_reg + 1'b1;
            wr_left_reg <= wr_left_reg - 1'b1;
            if (wr_last)
            begin
                res_status_reg <= STAT_OK;
                res_id_reg     <= OID_W'(next_owner_reg);
                res_start_reg  <= START_W'(where_reg);
                res_count_reg  <= CNT_W'(need_reg);
            end
        end

        if (cmd.emit)
        begin
            out_status_reg <= res_status_reg;
            out_id_reg     <= res_id_reg;
            out_start_reg  <= is_free ? START_W'(free_start_reg) : res_start_reg;
            out_count_reg  <= is_free ? CNT_W'(free_cnt_reg) : res_count_reg;
        end
    end

    always_comb
    begin
        stat.is_free    = is_free;
        stat.div_done   = div_done;
        stat.check_fail = chk_fail;
        stat.scan_done  = proc_vld_reg && proc_last_reg;
        stat.pick_fail  = !pick_ok;
        stat.wr_done    = wr_last;
        stat.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid       = out_valid_reg;
    assign out_status      = out_status_reg;
    assign out_owner_id    = out_id_reg;
    assign out_start_block = out_start_reg;
    assign out_block_count = out_count_reg;

endmodule
`default_nettype wire

FILE: sv/cba_ctrl.sv
`default_nettype none
module cba_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_is_free,
    output logic                in_ready,
    input  cba_pkg::cba_stat_t  stat,
    output cba_pkg::cba_cmd_t   cmd
);
    import cba_pkg::*;

    cba_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_is_free)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV;
                    end
                end
            end
            ST_DIV:
                if (stat.div_done)
                    state_next = ST_CHECK;
            ST_CHECK:
            begin
                cmd.check = 1'b1;
                if (stat.check_fail)
                    state_next = ST_FINISH;
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
                if (stat.scan_done)
                    state_next = stat.is_free ? ST_FINISH : ST_PICK;
            ST_PICK:
            begin
                cmd.pick   = 1'b1;
                state_next = stat.pick_fail ? ST_FINISH : ST_WRITE;
            end
            ST_WRITE:
            begin
                cmd.write = 1'b1;
                if (stat.wr_done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

FILE: bench/cba_alloc_checker.sv
`default_nettype none
module cba_alloc_checker
    import cba_pkg::*;
#(
    parameter int NUM_BLOCKS = 128,
    parameter int OWNER_BITS = 8
) (
    input  wire logic clk,
    input  wire logic rst_n,
    cba_req_if.sink   req_mon,
    cba_rsp_if.sink   rsp_mon,
    cba_cfg_if.sink   cfg_mon,
    output int        fail_count,
    output int        pending_count
);

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [OID_W-1:0]   owner_id;
        logic [START_W-1:0] start_block;
        logic [CNT_W-1:0]   block_count;
    } alloc_result_t;

    localparam int OWNER_LAST = (1 << OWNER_BITS) - 1;

    logic [OWNER_BITS-1:0] map_owner [NUM_BLOCKS];
    int                    id_next;
    int                    next_fit_pos;
    logic [BYTES_W-1:0]    blk_bytes;
    alloc_result_t         expected_results [$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    function automatic alloc_result_t model_item(input logic [KIND_W-1:0] kind,
                                                 input logic [BYTES_W-1:0] nbytes,
                                                 input logic [FOWN_W-1:0] fown);
        alloc_result_t r;
        int free_len [NUM_BLOCKS+1];
        int bs, need, where, best_len, p;
        bit found;
        r = '0;
        if (kind == KIND_FREE) begin
            found = 0;
            if (fown != 0)
                for (p = 0; p < NUM_BLOCKS; p++)
                    if (map_owner[p] == fown) begin
                        map_owner[p] = '0;
                        if (!found) r.start_block = START_W'(p);
                        found = 1;
                        r.block_count++;
                    end
            r.owner_id = fown;
            return r;
        end
        bs = (blk_bytes == 0) ? 1 : blk_bytes;
        need = (nbytes + bs - 1) / bs;
        if (need == 0) begin
            r.status = STAT_ZERO;
            return r;
        end
        if (id_next == 0) begin
            r.status = STAT_IDS;
            return r;
        end
        if (need > NUM_BLOCKS) begin
            r.status = STAT_NOFIT;
            return r;
        end
        free_len[NUM_BLOCKS] = 0;
        for (p = NUM_BLOCKS - 1; p >= 0; p--)
            free_len[p] = (map_owner[p] == 0) ? free_len[p+1] + 1 : 0;
        found = 0;
        where = 0;
        best_len = 0;
        if (kind == KIND_BEST) begin
            for (p = 0; p < NUM_BLOCKS; p++)
                if (map_owner[p] == 0 && (p == 0 || map_owner[p-1] != 0)
                    && free_len[p] >= need && (!found || free_len[p] < best_len)) begin
                    found = 1;
                    where = p;
                    best_len = free_len[p];
                end
        end else begin
            for (int off = 0; off < NUM_BLOCKS && !found; off++) begin
                p = ((kind == KIND_NEXT ? next_fit_pos : 0) + off) % NUM_BLOCKS;
                if (free_len[p] >= need) begin
                    found = 1;
                    where = p;
                end
            end
        end
        if (!found) begin
            r.status = STAT_NOFIT;
            return r;
        end
        for (p = 0; p < need; p++)
            map_owner[where+p] = OWNER_BITS'(id_next);
        r.owner_id = OID_W'(id_next);
        r.start_block = START_W'(where);
        r.block_count = CNT_W'(need);
        next_fit_pos = (where + need) % NUM_BLOCKS;
        id_next = (id_next >= OWNER_LAST) ? 0 : id_next + 1;
        return r;
    endfunction

    assign pending_count = expected_results.size();

    always @(posedge clk or negedge rst_n) begin
        alloc_result_t want;
        if (!rst_n) begin
            for (int i = 0; i < NUM_BLOCKS; i++)
                map_owner[i] <= '0;
            id_next <= 1;
            next_fit_pos <= 0;
            blk_bytes <= 1;
            fail_count <= 0;
            expected_results.delete();
        end else begin
            if (cfg_mon.valid && cfg_mon.ready)
                blk_bytes = cfg_mon.data;
            if (req_mon.valid && req_mon.ready)
                expected_results.push_back(model_item(req_mon.kind, req_mon.request_bytes,
                                                      req_mon.free_owner));
            if (rsp_mon.valid && rsp_mon.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected beat, owner", rsp_mon.owner_id, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (rsp_mon.status !== want.status)
                        report_mismatch("status", rsp_mon.status, want.status);
                    if (rsp_mon.owner_id !== want.owner_id)
                        report_mismatch("owner_id", rsp_mon.owner_id, want.owner_id);
                    if (rsp_mon.start_block !== want.start_block)
                        report_mismatch("start_block", rsp_mon.start_block,
                                        want.start_block);
                    if (rsp_mon.block_count !== want.block_count)
                        report_mismatch("block_count", rsp_mon.block_count,
                                        want.block_count);
                end
            end
        end
    end

endmodule
`default_nettype wire

FILE: bench/tb_contiguous_block_allocator_unit.sv
`default_nettype none
module tb_contiguous_block_allocator_unit;
    import cba_pkg::*;

    // The worst item plus a stalled rsp and a random send gap stays far below
    // this limit of cycles without any beat.
    localparam int IDLE_LIMIT = 5000;
    // Items can't be outstanding without a result, so a small settle suffices.
    localparam int SETTLE     = 300;

    logic clk = 0;
    logic rst_n = 0;

    cba_req_if req ();
    cba_rsp_if rsp ();
    cba_cfg_if cfg ();

    int fail_count;
    int pending_count;
    bit rsp_hold;      // long receiver hold-off, set by the stimulus
    int quiet_cycles = 0;

    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    contiguous_block_allocator_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    cba_alloc_checker i_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_mon       (req),
        .rsp_mon       (rsp),
        .cfg_mon       (cfg),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        req.valid = 0;
        req.kind = KIND_FIRST;
        req.request_bytes = '0;
        req.free_owner = '0;
        rsp.ready = 0;
        cfg.valid = 0;
        cfg.data = '0;
        rsp_hold = 0;
    end

    // Watchdog: cycles with no beat on any channel.
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: random stall per beat, or long hold when asked.
    // Quiet spells (drawn as 0) give back-to-back stretches.
    initial
    begin
        int wait_n;
        @(posedge rst_n);
        forever
        begin
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (wait_n != 0 || rsp_hold)
            begin
                rsp.ready <= 0;
                repeat (wait_n) @(posedge clk);
                while (rsp_hold) @(posedge clk);
            end
            rsp.ready <= 1;
            do @(posedge clk); while (!rsp.valid);
        end
    end

    // valid stays up after a beat; drain or a next call that draws a gap drops it
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [BYTES_W-1:0] nbytes,
                             input logic [FOWN_W-1:0] fown, input bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 16);
        if (gap != 0)
        begin
            req.valid <= 0;
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1;
        req.kind <= kind;
        req.request_bytes <= nbytes;
        req.free_owner <= fown;
        do @(posedge clk); while (!req.ready);
    endtask

    task automatic drain;
        req.valid <= 0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
    endtask

    // Block size is written only when nothing is in flight.
    task automatic set_block_size(input logic [BYTES_W-1:0] bsz);
        drain();
        repeat (SETTLE) @(posedge clk);
        cfg.valid <= 1;
        cfg.data <= bsz;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 0;
    endtask

    // Mostly allocations sized to fit, frees of random ids, some noise.
    task automatic random_phase(input int n, input int max_bytes);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: send_item(KIND_FREE, BYTES_W'($urandom),
                                   FOWN_W'($urandom_range(1, 255)));
                3: send_item(KIND_W'($urandom_range(0, 3)), BYTES_W'($urandom),
                             FOWN_W'($urandom));
                default: send_item(KIND_W'($urandom_range(0, 2)),
                                   BYTES_W'($urandom_range(1, max_bytes)),
                                   FOWN_W'($urandom));
            endcase
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed, block size 1 after reset.
        send_item(KIND_FIRST, 16'd0, 8'hFF);     // zero size
        send_item(KIND_FIRST, 16'd129, 8'h00);   // too many blocks
        send_item(KIND_FIRST, 16'hFFFF, 8'h00);
        send_item(KIND_FIRST, 16'd10, 8'h00);
        send_item(KIND_NEXT, 16'd5, 8'h00);
        send_item(KIND_BEST, 16'd20, 8'h00);
        send_item(KIND_FREE, 16'hFFFF, 8'd2);    // free middle run, leaves a hole
        send_item(KIND_BEST, 16'd3, 8'h00);      // best fit into the small hole
        send_item(KIND_FREE, 16'd0, 8'd0);       // free owner zero
        send_item(KIND_FREE, 16'd0, 8'd200);     // owner not in use
        send_item(KIND_FIRST, 16'd128, 8'h00);   // no room left
        send_item(KIND_FREE, 16'd0, 8'd1);
        send_item(KIND_FREE, 16'd0, 8'd3);
        send_item(KIND_FREE, 16'd0, 8'd4);
        send_item(KIND_FIRST, 16'd128, 8'h00);   // whole map
        send_item(KIND_NEXT, 16'd1, 8'h00);      // nothing free
        send_item(KIND_FREE, 16'd0, 8'd5);
        send_item(KIND_NEXT, 16'd100, 8'h00);    // next fit from block 0, where the pointer wrapped
        send_item(KIND_NEXT, 16'd50, 8'h00);

        // Pressure: receiver holds off while sender keeps offering.
        rsp_hold = 1;
        fork
            begin
                repeat (400) @(posedge clk);
                rsp_hold = 0;
            end
            for (int i = 0; i < 6; i++)
                send_item(KIND_FREE, 16'd0, FOWN_W'($urandom_range(1, 10)), 1);
        join
        drain();

        set_block_size(16'd0);       // treated as one
        random_phase(150, 40);
        set_block_size(16'hFFFF);
        send_item(KIND_FIRST, 16'hFFFF, 8'h00);
        send_item(KIND_FIRST, 16'd1, 8'h00);
        random_phase(100, 65535);
        set_block_size(16'd64);
        random_phase(250, 2000);
        set_block_size(16'd7);
        random_phase(300, 300);      // runs ids past 255 to exhaustion

        drain();
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
`default_nettype wire
